>>> hdl/pfs_pkg.sv
// Shared constants and types for the pipelined fetch stage.
`timescale 1ns / 1ps

package pfs_pkg;

    localparam int NUM_BANKS = 8;
    localparam int BANK_BITS = 3;
    localparam int WIN_BYTES = 6;

    localparam logic [3:0] IC_HALT  = 4'd0;
    localparam logic [3:0] IC_NOP   = 4'd1;
    localparam logic [3:0] IC_RRMOV = 4'd2;
    localparam logic [3:0] IC_IRMOV = 4'd3;
    localparam logic [3:0] IC_RMMOV = 4'd4;
    localparam logic [3:0] IC_MRMOV = 4'd5;
    localparam logic [3:0] IC_OP    = 4'd6;
    localparam logic [3:0] IC_JXX   = 4'd7;
    localparam logic [3:0] IC_CALL  = 4'd8;
    localparam logic [3:0] IC_RET   = 4'd9;
    localparam logic [3:0] IC_PUSH  = 4'd10;
    localparam logic [3:0] IC_POP   = 4'd11;
    localparam logic [3:0] IC_DUMP  = 4'd12;

    localparam logic [3:0] REG_NONE = 4'd15;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_CYCLE = 1'b1;

    localparam logic [1:0] STAT_AOK = 2'd0;
    localparam logic [1:0] STAT_ADR = 2'd1;
    localparam logic [1:0] STAT_HLT = 2'd2;
    localparam logic [1:0] STAT_INS = 2'd3;

    localparam logic [1:0] DACT_UPDATE = 2'd0;
    localparam logic [1:0] DACT_STALL  = 2'd1;
    localparam logic [1:0] DACT_BUBBLE = 2'd2;

    // fetch request waiting on its instruction bytes
    typedef struct packed {
        logic [31:0]            fpc;
        logic [BANK_BITS-1:0]   off;
        logic                   bad;
        logic [WIN_BYTES-1:0]   byte_ok;
        logic                   load_use;
        logic                   ret_pend;
        logic                   bubble;
    } s1_t;

endpackage

>>> hdl/pfs_if.sv
// Request and response channel interfaces of the fetch stage.
`timescale 1ns / 1ps

interface pfs_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic [3:0]  mem_icode;
    logic        mem_cond;
    logic [3:0]  wb_icode;
    logic [3:0]  ex_icode;
    logic        ex_cond;
    logic [3:0]  ex_dest_m;
    logic [3:0]  dec_icode;
    logic [3:0]  dec_src_a;
    logic [3:0]  dec_src_b;

    modport source (
        output valid, req_type, value_a, value_b, mem_icode, mem_cond, wb_icode,
               ex_icode, ex_cond, ex_dest_m, dec_icode, dec_src_a, dec_src_b,
        input  ready
    );
    modport sink (
        input  valid, req_type, value_a, value_b, mem_icode, mem_cond, wb_icode,
               ex_icode, ex_cond, ex_dest_m, dec_icode, dec_src_a, dec_src_b,
        output ready
    );
endinterface

interface pfs_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] fetch_pc;
    logic [1:0]  status;
    logic [3:0]  instr_code;
    logic [3:0]  instr_func;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic [31:0] const_value;
    logic [31:0] seq_pc;
    logic [31:0] next_pred_pc;
    logic [1:0]  decode_action;
    logic        fetch_stalled;

    modport source (
        output valid, fetch_pc, status, instr_code, instr_func, reg_a, reg_b,
               const_value, seq_pc, next_pred_pc, decode_action, fetch_stalled,
        input  ready
    );
    modport sink (
        input  valid, fetch_pc, status, instr_code, instr_func, reg_a, reg_b,
               const_value, seq_pc, next_pred_pc, decode_action, fetch_stalled,
        output ready
    );
endinterface

>>> hdl/pipelined_fetch_stage_with_hazards.sv
// Y86 fetch stage: banked instruction memory, PC select, decode, hazard control.
// Load request: writes one byte when accepted, if its address is below MEM_BYTES; no response.
// Cycle request: memory read and s1 registered at acceptance, response registered when s1 moves on;
// no new cycle request is accepted while s1 holds one (pred_pc -> memory read -> decode -> pred_pc loop).
// Reset: pred_pc cleared, then a clearing pass over all ceil(MEM_BYTES/8) rows zeroes
// the memory one row of all 8 banks per cycle; no request is accepted meanwhile.
`timescale 1ns / 1ps

module pipelined_fetch_stage_with_hazards #(
    parameter int MEM_BYTES = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    pfs_req_if.sink   req,
    pfs_rsp_if.source rsp
);
    import pfs_pkg::*;

    localparam int AW   = $clog2(MEM_BYTES);
    localparam int ROWS = (MEM_BYTES + NUM_BANKS - 1) / NUM_BANKS;
    localparam int RW   = AW - BANK_BITS;

    logic          clearing_reg;
    logic [RW-1:0] clr_row_reg;
    logic          s1_valid_reg;
    s1_t           s1_reg;
    s1_t           s1_next;
    logic [31:0]   pred_pc_reg;
    logic [31:0]   pred_pc_next;

    logic          out_valid_reg;
    logic [31:0]   out_fpc_reg;
    logic [1:0]    out_stat_reg;
    logic [3:0]    out_ic_reg;
    logic [3:0]    out_fn_reg;
    logic [3:0]    out_ra_reg;
    logic [3:0]    out_rb_reg;
    logic [31:0]   out_valc_reg;
    logic [31:0]   out_pc_reg;
    logic [31:0]   out_pred_reg;
    logic [1:0]    out_dact_reg;
    logic          out_stall_reg;

    logic          accept;
    logic          load_acc;
    logic          cyc_acc;
    logic          load_in_range;
    logic          s1_go;
    logic [31:0]   fpc;
    logic [RW-1:0] row0;
    logic [NUM_BANKS-1:0][7:0] rd_data;

    assign req.ready = !clearing_reg && !s1_valid_reg;
    assign accept    = req.valid && req.ready;
    assign load_acc  = accept && (req.req_type == REQ_LOAD);
    assign cyc_acc   = accept && (req.req_type == REQ_CYCLE);
    assign load_in_range = req.value_a < 32'(MEM_BYTES);
    assign s1_go     = s1_valid_reg && (!out_valid_reg || rsp.ready);

    // fetch PC select and hazard detection at acceptance
    always_comb
    begin
        logic lu;
        logic rp;
        logic [AW:0] addr_k;
        if (req.mem_icode == IC_JXX && !req.mem_cond)
            fpc = req.value_a;
        else if (req.wb_icode == IC_RET)
            fpc = req.value_b;
        else
            fpc = pred_pc_reg;
        row0 = fpc[AW-1:BANK_BITS];

        lu = (req.ex_icode == IC_MRMOV || req.ex_icode == IC_POP) &&
             (req.ex_dest_m == req.dec_src_a || req.ex_dest_m == req.dec_src_b);
        rp = req.dec_icode == IC_RET || req.ex_icode == IC_RET ||
             req.mem_icode == IC_RET;

        s1_next.fpc      = fpc;
        s1_next.off      = fpc[BANK_BITS-1:0];
        s1_next.bad      = fpc >= 32'(MEM_BYTES);
        s1_next.load_use = lu;
        s1_next.ret_pend = rp;
        s1_next.bubble   = (req.ex_icode == IC_JXX && !req.ex_cond) || (!lu && rp);
        for (int k = 0; k < WIN_BYTES; k++)
        begin
            addr_k = {1'b0, fpc[AW-1:0]} + (AW+1)'(k);
            s1_next.byte_ok[k] = addr_k < (AW+1)'(MEM_BYTES);
        end
    end

    // one byte per bank; a window of up to 6 bytes spans two rows at most
    for (genvar i = 0; i < NUM_BANKS; i++)
    begin : g_bank
        logic [7:0]    mem_bank [ROWS];
        logic [7:0]    rd_reg;
        logic [RW-1:0] rd_row;
        logic          wr_en;

        assign rd_row = row0 + RW'(BANK_BITS'(i) < fpc[BANK_BITS-1:0]);
        assign wr_en  = load_acc && load_in_range &&
                        (req.value_a[BANK_BITS-1:0] == BANK_BITS'(i));

        always_ff @(posedge clk)
        begin
            if (clearing_reg)
                mem_bank[clr_row_reg] <= 8'h00;
            else if (wr_en)
                mem_bank[req.value_a[AW-1:BANK_BITS]] <= req.value_b[7:0];
            if (cyc_acc)
                rd_reg <= mem_bank[rd_row];
        end

        assign rd_data[i] = rd_reg;
    end

    // decode of the registered window
    logic [WIN_BYTES-1:0][7:0] win;
    logic [3:0]  ic;
    logic [3:0]  fn;
    logic [1:0]  stat;
    logic [3:0]  ra;
    logic [3:0]  rb;
    logic [31:0] valc;
    logic [31:0] seq_pc;
    logic [2:0]  ilen;
    logic        has_reg;
    logic        has_const;
    logic        stall_f;
    logic [1:0]  dact;

    always_comb
    begin
        for (int k = 0; k < WIN_BYTES; k++)
            win[k] = s1_reg.byte_ok[k] ? rd_data[s1_reg.off + BANK_BITS'(k)] : 8'h00;

        if (s1_reg.bad)
        begin
            ic   = IC_NOP;
            fn   = 4'd0;
            stat = STAT_ADR;
        end
        else
        begin
            ic = win[0][7:4];
            fn = win[0][3:0];
            if (ic == IC_HALT)
                stat = STAT_HLT;
            else if (ic > IC_DUMP)
                stat = STAT_INS;
            else
                stat = STAT_AOK;
        end

        has_reg = ic == IC_RRMOV || ic == IC_OP || ic == IC_PUSH || ic == IC_POP ||
                  ic == IC_IRMOV || ic == IC_RMMOV || ic == IC_MRMOV;
        has_const = ic == IC_JXX || ic == IC_CALL || ic == IC_DUMP ||
                    ic == IC_IRMOV || ic == IC_RMMOV || ic == IC_MRMOV;

        ra = has_reg ? win[1][7:4] : REG_NONE;
        rb = has_reg ? win[1][3:0] : REG_NONE;
        if (!has_const)
            valc = 32'd0;
        else if (has_reg)
            valc = {win[5], win[4], win[3], win[2]};
        else
            valc = {win[4], win[3], win[2], win[1]};

        ilen   = 3'd1 + {2'b00, has_reg} + (has_const ? 3'd4 : 3'd0);
        seq_pc = s1_reg.fpc + {29'd0, ilen};

        stall_f = s1_reg.load_use || s1_reg.ret_pend;
        if (stall_f)
            pred_pc_next = pred_pc_reg;
        else if (ic == IC_JXX || ic == IC_CALL)
            pred_pc_next = valc;
        else
            pred_pc_next = seq_pc;

        if (s1_reg.bubble)
            dact = DACT_BUBBLE;
        else if (s1_reg.load_use)
            dact = DACT_STALL;
        else
            dact = DACT_UPDATE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_row_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            pred_pc_reg   <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                if (clr_row_reg == RW'(ROWS - 1))
                    clearing_reg <= 1'b0;
                clr_row_reg <= clr_row_reg + RW'(1);
            end

            if (cyc_acc)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;

            if (s1_go)
            begin
                pred_pc_reg   <= pred_pc_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cyc_acc)
            s1_reg <= s1_next;
        if (s1_go)
        begin
            out_fpc_reg   <= s1_reg.fpc;
            out_stat_reg  <= stat;
            out_ic_reg    <= ic;
            out_fn_reg    <= fn;
            out_ra_reg    <= ra;
            out_rb_reg    <= rb;
            out_valc_reg  <= valc;
            out_pc_reg    <= seq_pc;
            out_pred_reg  <= pred_pc_next;
            out_dact_reg  <= dact;
            out_stall_reg <= stall_f;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.fetch_pc      = out_fpc_reg;
    assign rsp.status        = out_stat_reg;
    assign rsp.instr_code    = out_ic_reg;
    assign rsp.instr_func    = out_fn_reg;
    assign rsp.reg_a         = out_ra_reg;
    assign rsp.reg_b         = out_rb_reg;
    assign rsp.const_value   = out_valc_reg;
    assign rsp.seq_pc        = out_pc_reg;
    assign rsp.next_pred_pc  = out_pred_reg;
    assign rsp.decode_action = out_dact_reg;
    assign rsp.fetch_stalled = out_stall_reg;

endmodule
